FILE: design/imu_fifo_burst_sorter_core_macros.svh
// Assertion macros used by the burst sorter checker.
`ifndef IMU_FIFO_BURST_SORTER_CORE_MACROS_SVH
`define IMU_FIFO_BURST_SORTER_CORE_MACROS_SVH

// Same-cycle implication, held off during reset.
`define IFBS_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define IFBS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: design/imu_fbs_pkg.sv
// Shared types, codes and defaults of the IMU FIFO burst sorter.
package imu_fbs_pkg;

  localparam int SAMPLE_CAP_DEF = 32;
  localparam int WORD_CAP_DEF   = 96;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_G_EN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_TAG   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_G_TAG  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_G_TAG = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_TAG   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_UPPER = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LOWER = 3'd6;

  // channel codes, also the upper address bits of the sample store
  localparam logic [1:0] CH_GYRO   = 2'd0;
  localparam logic [1:0] CH_LOW_G  = 2'd1;
  localparam logic [1:0] CH_HIGH_G = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_GYRO   = 2'd0;
  localparam logic [1:0] KIND_ACCEL  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam int SAMPLE_W = 48;

  typedef struct packed {
    logic               high_g_enable;
    logic [4:0]         gyro_tag;
    logic [4:0]         low_g_tag;
    logic [4:0]         high_g_tag;
    logic [4:0]         temp_tag;
    logic [14:0]        clip_upper;
    logic signed [15:0] clip_lower;
  } cfg_t;

  typedef struct packed {
    logic                is_sample;
    logic [1:0]          chan;
    logic                is_temp;
    logic                clips;
    logic [SAMPLE_W-1:0] sample;
  } dec_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic       high_g;
    logic       last;
  } meta_t;

endpackage

FILE: design/imu_fbs_decode.sv
// Tag decode, axis negation and low-g clip test of one FIFO word.
module imu_fbs_decode import imu_fbs_pkg::*; (
  input  logic [7:0]         tag_byte,
  input  logic signed [15:0] raw_x,
  input  logic signed [15:0] raw_y,
  input  logic signed [15:0] raw_z,
  input  cfg_t               cfg,
  output dec_t               dec
);

  logic [4:0]         tag;
  logic signed [15:0] y_neg;
  logic signed [15:0] z_neg;
  logic signed [15:0] upper;

  function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
    return (v == 16'sh8000) ? 16'sh7fff : -v;
  endfunction

  function automatic logic axis_clips(input logic signed [15:0] v,
                                      input logic signed [15:0] hi,
                                      input logic signed [15:0] lo);
    return (v >= hi) || (v <= lo);
  endfunction

  assign tag   = tag_byte[7:3];
  assign y_neg = neg_sat(raw_y);
  assign z_neg = neg_sat(raw_z);
  assign upper = $signed({1'b0, cfg.clip_upper});

  always_comb begin
    dec.is_sample = 1'b0;
    dec.chan      = CH_GYRO;
    dec.is_temp   = 1'b0;
    // first match wins when tag codes are equal
    if (tag == cfg.gyro_tag) begin
      dec.is_sample = 1'b1;
      dec.chan      = CH_GYRO;
    end else if (tag == cfg.low_g_tag) begin
      dec.is_sample = 1'b1;
      dec.chan      = CH_LOW_G;
    end else if (tag == cfg.high_g_tag) begin
      dec.is_sample = 1'b1;
      dec.chan      = CH_HIGH_G;
    end else if (tag == cfg.temp_tag) begin
      dec.is_temp = 1'b1;
    end
    dec.clips  = axis_clips(raw_x, upper, cfg.clip_lower) ||
                 axis_clips(y_neg, upper, cfg.clip_lower) ||
                 axis_clips(z_neg, upper, cfg.clip_lower);
    dec.sample = {z_neg, y_neg, raw_x};
  end

endmodule

FILE: design/imu_fbs_store.sv
// Sample store of all three channels: one write port, one registered read port.
module imu_fbs_store import imu_fbs_pkg::*; #(
  parameter int IDX_W = 5
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [IDX_W+1:0]    wr_addr,
  input  logic [SAMPLE_W-1:0] wr_data,
  input  logic                rd_en,
  input  logic [IDX_W+1:0]    rd_addr,
  output logic [SAMPLE_W-1:0] rd_data
);

  logic [SAMPLE_W-1:0] mem [0:(3 << IDX_W)-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/imu_fifo_burst_sorter_core.sv
// Top level of the IMU FIFO burst sorter: word intake, counters and burst-end emission.
//
//  channel   handshake               payload
//  -------   ---------------------   ------------------------------------------------
//  word in   start, busy             tag_byte, raw_x, raw_y, raw_z, burst_end
//  result    out_strobe              kind, from_high_g, out_x, out_y, out_z, run_last,
//                                    burst_good, low_g_clipped, temp_code, temp_seen
//  config    cfg_write               cfg_index, cfg_data
//
// Words are taken one per cycle while busy is low; a sample is stored in that cycle if it fits.
// After the burst-end word the block stays busy while it reads the G gyro and then the A chosen
// accel samples, one store read per cycle; each result comes in the cycle after its read.
// An empty burst gives its single status result in the next cycle with busy low.
// Reset clears counters, flags, last temperature and sequencer, not the store; config resets.
// Results are shown for one cycle each and are never held off.
module imu_fifo_burst_sorter_core import imu_fbs_pkg::*; #(
  parameter int SAMPLE_CAP = SAMPLE_CAP_DEF,
  parameter int WORD_CAP   = WORD_CAP_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [7:0]           tag_byte,
  input  logic signed [15:0]   raw_x,
  input  logic signed [15:0]   raw_y,
  input  logic signed [15:0]   raw_z,
  input  logic                 burst_end,
  output logic                 out_strobe,
  output logic [1:0]           kind,
  output logic                 from_high_g,
  output logic signed [15:0]   out_x,
  output logic signed [15:0]   out_y,
  output logic signed [15:0]   out_z,
  output logic                 run_last,
  output logic                 burst_good,
  output logic                 low_g_clipped,
  output logic signed [15:0]   temp_code,
  output logic                 temp_seen,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int IDX_W = (SAMPLE_CAP > 1) ? $clog2(SAMPLE_CAP) : 1;
  localparam int CNT_W = $clog2(SAMPLE_CAP + 1);
  localparam int WC_W  = $clog2(WORD_CAP + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  cfg_t cfg;
  dec_t dec;

  logic [CNT_W-1:0] gyro_count, low_g_count, high_g_count;
  logic [CNT_W-1:0] gyro_count_next, low_g_count_next, high_g_count_next;
  logic [WC_W-1:0]  word_count;
  logic             clip_seen, clip_seen_next;
  logic signed [15:0] last_temp, last_temp_next;
  logic             temp_flag, temp_flag_next;

  logic             state;
  logic             phase;
  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] run_gyro, run_acc;
  logic             run_hg;
  logic             fin_good, fin_clip, fin_temp_seen;
  logic signed [15:0] fin_temp;
  meta_t            meta;

  logic             accept, examined, room, wr_en;
  logic [CNT_W-1:0] chan_count;
  logic [IDX_W+1:0] wr_addr, rd_addr;
  logic [1:0]       rd_chan;
  logic [SAMPLE_W-1:0] rd_data;
  logic             rd_en;
  logic             end_clipped, end_use_hg, end_good, end_empty;
  logic [CNT_W-1:0] end_acc;
  logic [CNT_W-1:0] idx_ext;
  logic             gyro_done, last_issue;

  imu_fbs_decode u_decode (
    .tag_byte (tag_byte),
    .raw_x    (raw_x),
    .raw_y    (raw_y),
    .raw_z    (raw_z),
    .cfg      (cfg),
    .dec      (dec)
  );

  imu_fbs_store #(.IDX_W(IDX_W)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (dec.sample),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy     = (state == ST_RUN);
  assign accept   = start && !busy;
  assign examined = (word_count < WC_W'(WORD_CAP));

  always_comb begin
    case (dec.chan)
      CH_LOW_G:  chan_count = low_g_count;
      CH_HIGH_G: chan_count = high_g_count;
      default:   chan_count = gyro_count;
    endcase
  end

  assign room    = (chan_count < CNT_W'(SAMPLE_CAP));
  assign wr_en   = accept && examined && dec.is_sample && room;
  assign wr_addr = {dec.chan, chan_count[IDX_W-1:0]};

  always_comb begin
    gyro_count_next   = gyro_count;
    low_g_count_next  = low_g_count;
    high_g_count_next = high_g_count;
    clip_seen_next    = clip_seen;
    last_temp_next    = last_temp;
    temp_flag_next    = temp_flag;
    if (wr_en) begin
      case (dec.chan)
        CH_LOW_G: begin
          low_g_count_next = low_g_count + 1'b1;
          clip_seen_next   = clip_seen || dec.clips;
        end
        CH_HIGH_G: high_g_count_next = high_g_count + 1'b1;
        default:   gyro_count_next   = gyro_count + 1'b1;
      endcase
    end
    if (accept && examined && dec.is_temp) begin
      last_temp_next = raw_x;
      temp_flag_next = 1'b1;
    end
  end

  // burst status, from the counts including the final word
  assign end_clipped = cfg.high_g_enable && clip_seen_next;
  assign end_use_hg  = end_clipped && (high_g_count_next != '0);
  assign end_acc     = end_use_hg ? high_g_count_next : low_g_count_next;
  assign end_good    = (end_use_hg || (low_g_count_next != '0)) && (gyro_count_next != '0);
  assign end_empty   = (gyro_count_next == '0) && (end_acc == '0);

  // read sequencer
  assign idx_ext    = CNT_W'(idx);
  assign gyro_done  = (idx_ext == run_gyro - 1'b1);
  assign last_issue = phase ? (idx_ext == run_acc - 1'b1) : (gyro_done && (run_acc == '0));
  assign rd_chan    = phase ? (run_hg ? CH_HIGH_G : CH_LOW_G) : CH_GYRO;
  assign rd_addr    = {rd_chan, idx};
  assign rd_en      = (state == ST_RUN);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.high_g_enable <= 1'b0;
      cfg.gyro_tag      <= 5'd1;
      cfg.low_g_tag     <= 5'd2;
      cfg.high_g_tag    <= 5'd29;
      cfg.temp_tag      <= 5'd3;
      cfg.clip_upper    <= 15'd23069;
      cfg.clip_lower    <= -16'sd23070;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_HIGH_G_EN:  cfg.high_g_enable <= cfg_data[0];
        REG_GYRO_TAG:   cfg.gyro_tag      <= cfg_data[4:0];
        REG_LOW_G_TAG:  cfg.low_g_tag     <= cfg_data[4:0];
        REG_HIGH_G_TAG: cfg.high_g_tag    <= cfg_data[4:0];
        REG_TEMP_TAG:   cfg.temp_tag      <= cfg_data[4:0];
        REG_CLIP_UPPER: cfg.clip_upper    <= cfg_data[14:0];
        REG_CLIP_LOWER: cfg.clip_lower    <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_count   <= '0;
      low_g_count  <= '0;
      high_g_count <= '0;
      word_count   <= '0;
      clip_seen    <= 1'b0;
      last_temp    <= '0;
      temp_flag    <= 1'b0;
      state        <= ST_IDLE;
      phase        <= 1'b0;
      idx          <= '0;
      meta         <= '0;
    end else begin
      last_temp  <= last_temp_next;
      if (accept) begin
        if (burst_end) begin
          gyro_count   <= '0;
          low_g_count  <= '0;
          high_g_count <= '0;
          word_count   <= '0;
          clip_seen    <= 1'b0;
          temp_flag    <= 1'b0;
          idx          <= '0;
          phase        <= (gyro_count_next == '0);
          if (!end_empty) begin
            state <= ST_RUN;
          end
        end else begin
          gyro_count   <= gyro_count_next;
          low_g_count  <= low_g_count_next;
          high_g_count <= high_g_count_next;
          clip_seen    <= clip_seen_next;
          temp_flag    <= temp_flag_next;
          if (examined) begin
            word_count <= word_count + 1'b1;
          end
        end
      end
      if (state == ST_RUN) begin
        meta <= '{valid: 1'b1, kind: (phase ? KIND_ACCEL : KIND_GYRO),
                  high_g: phase && run_hg, last: last_issue};
        if (last_issue) begin
          state <= ST_IDLE;
        end else if (!phase && gyro_done) begin
          phase <= 1'b1;
          idx   <= '0;
        end else begin
          idx <= idx + 1'b1;
        end
      end else if (accept && burst_end && end_empty) begin
        // nothing stored: status word alone
        meta <= '{valid: 1'b1, kind: KIND_STATUS, high_g: 1'b0, last: 1'b1};
      end else begin
        meta.valid <= 1'b0;
      end
    end
  end

  // burst summary, held for the whole emission
  always_ff @(posedge clk) begin
    if (accept && burst_end) begin
      run_gyro      <= gyro_count_next;
      run_acc       <= end_acc;
      run_hg        <= end_use_hg;
      fin_good      <= end_good;
      fin_clip      <= end_clipped;
      fin_temp      <= last_temp_next;
      fin_temp_seen <= temp_flag_next;
    end
  end

  assign out_strobe    = meta.valid;
  assign kind          = meta.kind;
  assign from_high_g   = meta.high_g;
  assign run_last      = meta.last;
  assign out_x         = (meta.kind == KIND_STATUS) ? '0 : $signed(rd_data[15:0]);
  assign out_y         = (meta.kind == KIND_STATUS) ? '0 : $signed(rd_data[31:16]);
  assign out_z         = (meta.kind == KIND_STATUS) ? '0 : $signed(rd_data[47:32]);
  assign burst_good    = meta.last && fin_good;
  assign low_g_clipped = meta.last && fin_clip;
  assign temp_code     = meta.last ? fin_temp : '0;
  assign temp_seen     = meta.last && fin_temp_seen;

endmodule

FILE: design/imu_fbs_checker.sv
// Port-level checks of the burst sorter and their binding to the top level.
`include "imu_fifo_burst_sorter_core_macros.svh"

module imu_fbs_checker import imu_fbs_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               burst_end,
  input logic               out_strobe,
  input logic [1:0]         kind,
  input logic               from_high_g,
  input logic signed [15:0] out_x,
  input logic               run_last,
  input logic               burst_good,
  input logic               low_g_clipped,
  input logic signed [15:0] temp_code,
  input logic               temp_seen
);

  `IFBS_ASSERT_NOW(a_more_follow_busy, out_strobe && !run_last, busy, "word before last without busy")
  `IFBS_ASSERT_NOW(a_status_alone, out_strobe && (kind == KIND_STATUS), run_last && (out_x == 16'sd0) && !from_high_g, "status word malformed")
  `IFBS_ASSERT_NOW(a_summary_on_last, out_strobe && !run_last, !burst_good && !low_g_clipped && !temp_seen && (temp_code == 16'sd0), "summary before last word")
  `IFBS_ASSERT_NOW(a_gyro_not_hg, out_strobe && (kind == KIND_GYRO), !from_high_g, "gyro word marked high-g")
  `IFBS_ASSERT_NEXT(a_quiet_after_word, start && !busy && !burst_end, !out_strobe, "result after a mid-burst word")

endmodule

bind imu_fifo_burst_sorter_core imu_fbs_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .burst_end     (burst_end),
  .out_strobe    (out_strobe),
  .kind          (kind),
  .from_high_g   (from_high_g),
  .out_x         (out_x),
  .run_last      (run_last),
  .burst_good    (burst_good),
  .low_g_clipped (low_g_clipped),
  .temp_code     (temp_code),
  .temp_seen     (temp_seen)
);
